FILE: hdl/nll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nll_pkg
// shared widths, register codes, controller commands and the tanh table
// ----------------------------------------------------------------------------
package nll_pkg;

	localparam int STAGE_WIDTH      = 24;
	localparam int TANH_TABLE_DEPTH = 256;
	localparam int NUM_STAGES       = 4;

	localparam int STAGE_FRAC  = STAGE_WIDTH - 4;
	localparam int TH_FRAC     = 16;
	localparam int COEF_FRAC   = 16;
	localparam int SAMPLE_W    = 16;
	localparam int SAMPLE_FRAC = 15;
	localparam int CFG_W       = 19;
	localparam int CFG_INDEX_W = 1;
	localparam int STAGE_IDX_W = 2;

	// tanh values in [-1, 1] with TH_FRAC fraction bits
	localparam int TH_W   = TH_FRAC + 2;
	localparam int DIFF_W = TH_W + 1;
	// feedback sum, not saturated
	localparam int X_W    = STAGE_WIDTH + 4;
	// offset tanh argument over [0, 8)
	localparam int U_W    = STAGE_FRAC + 3;
	localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);
	localparam int TIDX_W = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int P_W    = U_W + IDX_W;
	// shared multiplier operands and product
	localparam int MA_W   = (STAGE_WIDTH > DIFF_W) ? STAGE_WIDTH : DIFF_W;
	localparam int MB_W   = (CFG_W > U_W) ? CFG_W : U_W;
	localparam int PROD_W = MA_W + MB_W + 1;
	// stage update sum and output rescale widths
	localparam int ADD_W  = STAGE_WIDTH + 3;
	localparam int OUT_W  = STAGE_WIDTH + 2;

	localparam logic [CFG_INDEX_W-1:0] REG_TUNING   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK = CFG_INDEX_W'(1);

	localparam logic [CFG_W-1:0] TUNING_RESET   = CFG_W'(4295);
	localparam logic [CFG_W-1:0] FEEDBACK_RESET = CFG_W'(131072);

	localparam logic [STAGE_IDX_W-1:0] STAGE_FIRST = STAGE_IDX_W'(0);
	localparam logic [STAGE_IDX_W-1:0] STAGE_LAST  = STAGE_IDX_W'(NUM_STAGES - 1);

	// shared multiplier operand select
	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_FB     = 2'd0;
	localparam mul_sel_t MUL_INTERP = 2'd1;
	localparam mul_sel_t MUL_TUNE   = 2'd2;

	typedef struct packed {
		logic                   load_sample;
		logic                   mul_en;
		mul_sel_t               mul_sel;
		logic                   load_x;
		logic                   idx_en;
		logic                   idx_self;
		logic [STAGE_IDX_W-1:0] stage_k;
		logic                   rd_en;
		logic                   thp_en;
		logic                   ths_en;
		logic                   upd_en;
		logic                   load_out;
	} dp_cmd_t;

	typedef logic signed [TH_W-1:0] tanh_tab_t [TANH_TABLE_DEPTH+1];

	// shift-subtract unsigned quotient for the table build
	function automatic longint unsigned div_u64(input longint unsigned dividend,
			input longint unsigned divisor);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], dividend[b]};
			if (rem >= divisor) begin
				rem    = rem - divisor;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// tanh(a) = (1-e)/(1+e), e = exp(-2a), exp(-a/8) as a taylor sum in q30
	// squared four times; evaluated at elaboration only
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t         tab;
		longint            num;
		longint            e;
		longint unsigned   mag;
		longint unsigned   q;
		longint unsigned   term;
		longint unsigned   n2;
		longint unsigned   d2;
		longint unsigned   t;
		bit                neg;
		longint            one;
		for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
			one = longint'(1) << 30;
			num = longint'(i) * 8 - longint'(4) * longint'(TANH_TABLE_DEPTH);
			neg = (num < 0);
			mag = neg ? longint'(-num) : longint'(num);
			q = div_u64(mag << 30, longint'(TANH_TABLE_DEPTH) * 8);
			term = one;
			e = one;
			for (int n = 1; n <= 12; n++) begin
				term = div_u64((term * q) >> 30, longint'(n));
				if (n[0])
					e = e - longint'(term);
				else
					e = e + longint'(term);
			end
			for (int s = 0; s < 4; s++)
				e = longint'((longint'(e) * longint'(e) + (longint'(1) << 29)) >> 30);
			n2 = longint'(one - e) << (TH_FRAC + 1);
			d2 = longint'(one + e);
			t = div_u64(n2 + d2, 2 * d2);
			tab[i] = neg ? TH_W'(-longint'(t)) : TH_W'(longint'(t));
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage
`default_nettype wire

FILE: hdl/nll_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nll_in_if
// sample channel: valid, ready and one q1.15 audio word
// ----------------------------------------------------------------------------
interface nll_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [nll_pkg::SAMPLE_W-1:0]   sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/nll_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nll_out_if
// result channel: valid, ready and one filtered q1.15 word
// ----------------------------------------------------------------------------
interface nll_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [nll_pkg::SAMPLE_W-1:0]   sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/nll_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nll_datapath
// ladder stages, coefficient registers, shared multiplier and tanh lookup
// ----------------------------------------------------------------------------
module nll_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [nll_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [nll_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic signed [nll_pkg::SAMPLE_W-1:0]   sample_in,
	input  wire nll_pkg::dp_cmd_t                      cmd,
	output logic signed [nll_pkg::SAMPLE_W-1:0]        sample_out
);

	localparam int SW  = nll_pkg::STAGE_WIDTH;
	localparam int SF  = nll_pkg::STAGE_FRAC;
	localparam int XW  = nll_pkg::X_W;
	localparam int UW  = nll_pkg::U_W;
	localparam int PW  = nll_pkg::P_W;
	localparam int TW  = nll_pkg::TH_W;
	localparam int DW  = nll_pkg::DIFF_W;
	localparam int PRW = nll_pkg::PROD_W;
	localparam int AW  = nll_pkg::ADD_W;
	localparam int OW  = nll_pkg::OUT_W;

	// sample to stage format
	localparam int S_SHL = (SF >= nll_pkg::SAMPLE_FRAC) ? SF - nll_pkg::SAMPLE_FRAC : 0;
	localparam int S_SHR = (SF < nll_pkg::SAMPLE_FRAC) ? nll_pkg::SAMPLE_FRAC - SF : 0;
	localparam logic signed [XW-1:0] S_RND =
		(S_SHR > 0) ? XW'(longint'(1) << (S_SHR - 1)) : XW'(0);
	// stage to output format
	localparam int O_SHR = (SF > nll_pkg::SAMPLE_FRAC) ? SF - nll_pkg::SAMPLE_FRAC : 0;
	localparam int O_SHL = (SF < nll_pkg::SAMPLE_FRAC) ? nll_pkg::SAMPLE_FRAC - SF : 0;
	localparam logic signed [OW-1:0] O_RND =
		(O_SHR > 0) ? OW'(longint'(1) << (O_SHR - 1)) : OW'(0);
	localparam logic signed [OW-1:0] O_MAX = OW'((longint'(1) << (nll_pkg::SAMPLE_W - 1)) - 1);
	localparam logic signed [OW-1:0] O_MIN = OW'(-(longint'(1) << (nll_pkg::SAMPLE_W - 1)));
	// feedback product drops the coefficient fraction
	localparam logic signed [PRW-1:0] FB_RND = PRW'(longint'(1) << (nll_pkg::COEF_FRAC - 1));
	// tuning product goes from 2*TH_FRAC fraction bits to SF
	localparam int D_SHR = 2 * nll_pkg::TH_FRAC - SF;
	localparam logic signed [PRW-1:0] D_RND = PRW'(longint'(1) << (D_SHR - 1));
	localparam logic signed [AW-1:0] ST_MAX = AW'((longint'(1) << (SW - 1)) - 1);
	localparam logic signed [AW-1:0] ST_MIN = AW'(-(longint'(1) << (SW - 1)));
	// tanh table span
	localparam logic signed [XW-1:0] T_LIM  = XW'(longint'(4) << SF);
	localparam logic signed [XW-1:0] T_NLIM = XW'(-(longint'(4) << SF));
	localparam logic [PW-1:0] DEPTH_K = PW'(nll_pkg::TANH_TABLE_DEPTH);
	localparam logic signed [TW-1:0] TH_ONE  = TW'(longint'(1) << nll_pkg::TH_FRAC);
	localparam logic signed [TW-1:0] TH_NONE = TW'(-(longint'(1) << nll_pkg::TH_FRAC));

	logic [nll_pkg::CFG_W-1:0]            tuning_q;
	logic [nll_pkg::CFG_W-1:0]            feedback_q;
	logic signed [SW-1:0]                 stage_q [nll_pkg::NUM_STAGES];
	logic signed [nll_pkg::SAMPLE_W-1:0]  sample_q;
	logic signed [XW-1:0]                 prev_q;
	logic signed [PRW-1:0]                prod_q;
	logic [nll_pkg::IDX_W-1:0]            idx_q;
	logic [UW-1:0]                        frac_q;
	logic                                 sat_hi_q;
	logic                                 sat_lo_q;
	logic signed [TW-1:0]                 a_q;
	logic signed [DW-1:0]                 diff_q;
	logic signed [TW-1:0]                 thp_q;
	logic signed [TW-1:0]                 ths_q;
	logic signed [nll_pkg::SAMPLE_W-1:0]  out_q;

	logic signed [SW-1:0]                 self_st;
	logic signed [XW-1:0]                 t_op;
	logic signed [XW-1:0]                 t_sum;
	logic [PW-1:0]                        t_p;
	logic [nll_pkg::TIDX_W-1:0]           rd_addr;
	logic signed [TW-1:0]                 tab_a;
	logic signed [TW-1:0]                 tab_b;
	logic signed [nll_pkg::MA_W-1:0]      mul_a;
	logic [nll_pkg::MB_W-1:0]             mul_b;
	logic signed [PRW-1:0]                mul_p;
	logic signed [DW-1:0]                 th_d;
	logic signed [DW-1:0]                 th_sum;
	logic signed [TW-1:0]                 th_val;
	logic signed [PRW-1:0]                fb_full;
	logic signed [XW-1:0]                 xs;
	logic signed [XW-1:0]                 x_next;
	logic signed [PRW-1:0]                dl_full;
	logic signed [AW-1:0]                 upd_sum;
	logic signed [SW-1:0]                 stage_new;
	logic signed [OW-1:0]                 o_full;
	logic signed [nll_pkg::SAMPLE_W-1:0]  o_sat;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_q   <= nll_pkg::TUNING_RESET;
			feedback_q <= nll_pkg::FEEDBACK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nll_pkg::REG_TUNING:   tuning_q   <= cfg_data;
				nll_pkg::REG_FEEDBACK: feedback_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tanh index from the previous stage or from the stage itself
	always_comb begin
		self_st = stage_q[cmd.stage_k];
		t_op    = cmd.idx_self ? XW'(self_st) : prev_q;
		t_sum   = t_op + T_LIM;
		t_p     = PW'(t_sum[UW-1:0]) * DEPTH_K;
	end

	// neighboring table points
	always_comb begin
		rd_addr = nll_pkg::TIDX_W'(idx_q);
		tab_a   = nll_pkg::TANH_TAB[rd_addr];
		tab_b   = nll_pkg::TANH_TAB[rd_addr + nll_pkg::TIDX_W'(1)];
	end

	// shared multiplier
	always_comb begin
		th_d = DW'(thp_q) - DW'(ths_q);
		unique case (cmd.mul_sel)
			nll_pkg::MUL_FB: begin
				mul_a = nll_pkg::MA_W'(stage_q[nll_pkg::STAGE_LAST]);
				mul_b = nll_pkg::MB_W'(feedback_q);
			end
			nll_pkg::MUL_INTERP: begin
				mul_a = nll_pkg::MA_W'(diff_q);
				mul_b = nll_pkg::MB_W'(frac_q);
			end
			nll_pkg::MUL_TUNE: begin
				mul_a = nll_pkg::MA_W'(th_d);
				mul_b = nll_pkg::MB_W'(tuning_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = PRW'(mul_a) * PRW'($signed({1'b0, mul_b}));
	end

	// interpolated tanh, clipped to +-1 outside the table span
	always_comb begin
		th_sum = DW'(a_q) + DW'(prod_q >>> UW);
		if (sat_hi_q)
			th_val = TH_ONE;
		else if (sat_lo_q)
			th_val = TH_NONE;
		else
			th_val = TW'(th_sum);
	end

	// feedback sum
	always_comb begin
		fb_full = (prod_q + FB_RND) >>> nll_pkg::COEF_FRAC;
		xs      = ((XW'(sample_q) + S_RND) >>> S_SHR) <<< S_SHL;
		x_next  = xs - XW'(fb_full);
	end

	// stage update with saturation
	always_comb begin
		dl_full = (prod_q + D_RND) >>> D_SHR;
		upd_sum = AW'(self_st) + AW'(dl_full);
		if (upd_sum > ST_MAX)
			stage_new = SW'(ST_MAX);
		else if (upd_sum < ST_MIN)
			stage_new = SW'(ST_MIN);
		else
			stage_new = SW'(upd_sum);
	end

	// output rescale and saturation
	always_comb begin
		o_full = ((OW'(stage_q[nll_pkg::STAGE_LAST]) + O_RND) >>> O_SHR) <<< O_SHL;
		if (o_full > O_MAX)
			o_sat = nll_pkg::SAMPLE_W'(O_MAX);
		else if (o_full < O_MIN)
			o_sat = nll_pkg::SAMPLE_W'(O_MIN);
		else
			o_sat = nll_pkg::SAMPLE_W'(o_full);
	end

	// ladder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nll_pkg::NUM_STAGES; i++)
				stage_q[i] <= '0;
		end else if (cmd.upd_en) begin
			stage_q[cmd.stage_k] <= stage_new;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_sample)
			sample_q <= sample_in;
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.load_x)
			prev_q <= x_next;
		else if (cmd.upd_en)
			prev_q <= XW'(stage_new);
		if (cmd.idx_en) begin
			idx_q    <= t_p[PW-1:UW];
			frac_q   <= t_p[UW-1:0];
			sat_hi_q <= (t_op >= T_LIM);
			sat_lo_q <= (t_op < T_NLIM);
		end
		if (cmd.rd_en) begin
			a_q    <= tab_a;
			diff_q <= DW'(tab_b) - DW'(tab_a);
		end
		if (cmd.thp_en)
			thp_q <= th_val;
		if (cmd.ths_en)
			ths_q <= th_val;
		if (cmd.load_out)
			out_q <= o_sat;
	end

	assign sample_out = out_q;

endmodule
`default_nettype wire

FILE: hdl/nll_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nll_ctrl
// sequencer for the feedback sum, four stage updates and the output word
// ----------------------------------------------------------------------------
module nll_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output nll_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FB    = 4'd1;
	localparam logic [3:0] ST_X     = 4'd2;
	localparam logic [3:0] ST_IDX_P = 4'd3;
	localparam logic [3:0] ST_RD_P  = 4'd4;
	localparam logic [3:0] ST_MUL_P = 4'd5;
	localparam logic [3:0] ST_TH_P  = 4'd6;
	localparam logic [3:0] ST_RD_S  = 4'd7;
	localparam logic [3:0] ST_MUL_S = 4'd8;
	localparam logic [3:0] ST_TH_S  = 4'd9;
	localparam logic [3:0] ST_MUL_D = 4'd10;
	localparam logic [3:0] ST_UPD   = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [3:0]                        state_q;
	logic [3:0]                        state_d;
	logic [nll_pkg::STAGE_IDX_W-1:0]   k_q;
	logic                              out_valid_q;
	logic                              k_last;

	assign k_last = (k_q == nll_pkg::STAGE_LAST);

	always_comb begin
		cmd         = '0;
		cmd.stage_k = k_q;
		cmd.mul_sel = nll_pkg::MUL_FB;
		state_d     = state_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d = ST_FB;
				end
			end
			ST_FB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = nll_pkg::MUL_FB;
				state_d = ST_X;
			end
			ST_X: begin
				cmd.load_x = 1'b1;
				state_d = ST_IDX_P;
			end
			ST_IDX_P: begin
				cmd.idx_en = 1'b1;
				state_d = ST_RD_P;
			end
			ST_RD_P: begin
				cmd.rd_en = 1'b1;
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = nll_pkg::MUL_INTERP;
				state_d = ST_TH_P;
			end
			ST_TH_P: begin
				// finish tanh(prev) while indexing tanh(self)
				cmd.thp_en   = 1'b1;
				cmd.idx_en   = 1'b1;
				cmd.idx_self = 1'b1;
				state_d = ST_RD_S;
			end
			ST_RD_S: begin
				cmd.rd_en = 1'b1;
				state_d = ST_MUL_S;
			end
			ST_MUL_S: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = nll_pkg::MUL_INTERP;
				state_d = ST_TH_S;
			end
			ST_TH_S: begin
				cmd.ths_en = 1'b1;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = nll_pkg::MUL_TUNE;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_en = 1'b1;
				state_d = k_last ? ST_OUT : ST_IDX_P;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= nll_pkg::STAGE_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_X)
				k_q <= nll_pkg::STAGE_FIRST;
			else if (state_q == ST_UPD && !k_last)
				k_q <= k_q + nll_pkg::STAGE_IDX_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a finished word never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// the output step comes only after the last stage update
	a_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && $past(state_q) == ST_UPD) |-> k_last)
		else $error("output before last stage");

	// an accepted word starts the feedback product next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_FB)
		else $error("accepted word not started");

	// output valid drops only when the word was taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("output word dropped");

endmodule
`default_nettype wire

FILE: hdl/nonlinear_ladder_lowpass_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass_top: four-pole nonlinear ladder lowpass
// one sample word at a time: the next word is taken only after the last
//   result word is loaded, since the four stage updates use the one shared
//   multiplier and tanh lookup in turn
// reset: stages clear, tuning 4295 and feedback 131072 (q.16), no word held
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [nll_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [nll_pkg::CFG_W-1:0]         cfg_data,
	nll_in_if.sink                                 sample,
	nll_out_if.source                              result
);

	// command bundle from sequencer to datapath
	nll_pkg::dp_cmd_t cmd;

	// sequencer: one sample at a time, feedback sum then stages 0..3,
	// each stage = tanh(prev), tanh(self), tuning product, saturating add
	nll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// datapath: coefficient registers, ladder stages, shared multiplier,
	// interpolated tanh table and the output word register
	nll_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample.sample_in),
		.cmd        (cmd),
		.sample_out (result.sample_out)
	);

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: nonlinear ladder lowpass testbench
// feeds q1.15 sample words through the valid/ready channels, runs a bit-exact
// fixed-point ladder model next to the block and checks every filtered word
// in order, over several coefficient settings and idle/stall patterns
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_W            = nll_pkg::CFG_W;
	localparam int CFG_INDEX_W      = nll_pkg::CFG_INDEX_W;
	localparam int STAGE_WIDTH      = nll_pkg::STAGE_WIDTH;
	localparam int STAGE_FRAC       = nll_pkg::STAGE_FRAC;
	localparam int TANH_TABLE_DEPTH = nll_pkg::TANH_TABLE_DEPTH;
	localparam int NUM_STAGES       = nll_pkg::NUM_STAGES;
	localparam int SAMPLE_W         = nll_pkg::SAMPLE_W;
	localparam int SAMPLE_FRAC      = nll_pkg::SAMPLE_FRAC;
	localparam int TH_FRAC          = nll_pkg::TH_FRAC;
	localparam int COEF_FRAC        = nll_pkg::COEF_FRAC;

	// long receiver stall, watchdog and settle after the last word
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_TAIL  = 45;
	localparam int PHASE_WORDS  = 100;
	localparam int NUM_PHASES   = 8;

	localparam logic [CFG_W-1:0] TUNING_TOP   = CFG_W'(425984);
	localparam logic [CFG_W-1:0] FEEDBACK_TOP = CFG_W'(262144);
	localparam logic [CFG_W-1:0] CFG_FULL     = '1;

	localparam longint STAGE_HI = (longint'(1) <<< (STAGE_WIDTH - 1)) - 1;
	localparam longint STAGE_LO = -STAGE_HI - 1;

	// shapes of the random sample runs
	typedef enum int {
		SHAPE_NOISE,
		SHAPE_STEP,
		SHAPE_QUIET,
		SHAPE_SQUARE
	} shape_t;

	logic clk;
	logic arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	nll_in_if  sample_if ();
	nll_out_if result_if ();

	nonlinear_ladder_lowpass_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if),
		.result    (result_if)
	);

	// ladder model: tanh points with 16 fraction bits, stages at full width
	longint           tanh_points [TANH_TABLE_DEPTH+1];
	longint           ladder_state [NUM_STAGES];
	logic [CFG_W-1:0] tuning_now;
	logic [CFG_W-1:0] feedback_now;

	// words waiting to go in, and filtered words the block still owes
	logic signed [SAMPLE_W-1:0] samples_to_send [$];
	logic signed [SAMPLE_W-1:0] filtered_due [$];
	logic signed [SAMPLE_W-1:0] filtered_want;

	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_requests;
	int holds_served;
	int hold_left;
	int quiet_cycles;
	int words_sent;
	int words_checked;
	int failures;
	int settings_used;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// tanh(a) = (1-e)/(1+e) with e = exp(-2a); exp(-|a|/8) is a 13-term
	// taylor sum in q30, then squared four times with rounding
	function automatic void build_tanh_points();
		longint          offset;
		longint unsigned mag;
		longint unsigned q;
		longint unsigned term;
		longint unsigned e;
		longint unsigned n2;
		longint unsigned d2;
		longint unsigned t;
		longint unsigned unity;
		unity = longint'(1) << 30;
		for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
			offset = longint'(i) * 8 - longint'(4) * TANH_TABLE_DEPTH;
			mag = (offset < 0) ? -offset : offset;
			q = (mag << 30) / (longint'(TANH_TABLE_DEPTH) * 8);
			term = unity;
			e = unity;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * q) >> 30) / longint'(n);
				if (n % 2 == 1)
					e = e - term;
				else
					e = e + term;
			end
			for (int s = 0; s < 4; s++)
				e = (e * e + (longint'(1) << 29)) >> 30;
			n2 = (unity - e) << (TH_FRAC + 1);
			d2 = unity + e;
			t = (n2 + d2) / (2 * d2);
			tanh_points[i] = (offset < 0) ? -longint'(t) : longint'(t);
		end
	endfunction

	// round to nearest, half up, dropping n fraction bits
	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// interpolated tanh of a stage-format value, flat at +-1 past +-4
	function automatic longint tanh_q16(longint v);
		longint lim;
		longint p;
		longint idx;
		longint frac;
		longint a;
		longint b;
		lim = longint'(4) <<< STAGE_FRAC;
		if (v >= lim)
			return longint'(1) <<< TH_FRAC;
		if (v < -lim)
			return -(longint'(1) <<< TH_FRAC);
		p = (v + lim) * TANH_TABLE_DEPTH;
		idx = p >>> (STAGE_FRAC + 3);
		frac = p & ((longint'(8) <<< STAGE_FRAC) - 1);
		if (idx > TANH_TABLE_DEPTH - 1)
			idx = TANH_TABLE_DEPTH - 1;
		a = tanh_points[idx];
		b = tanh_points[idx+1];
		return a + (((b - a) * frac) >>> (STAGE_FRAC + 3));
	endfunction

	// one sample through the ladder; returns stage 3 as a q1.15 word
	function automatic logic signed [SAMPLE_W-1:0] ladder_advance(
		logic signed [SAMPLE_W-1:0] s
	);
		longint drive;
		longint diff;
		longint step;
		drive = (longint'(s) <<< (STAGE_FRAC - SAMPLE_FRAC))
			- round_shift(longint'(feedback_now) * ladder_state[NUM_STAGES-1], COEF_FRAC);
		for (int k = 0; k < NUM_STAGES; k++) begin
			diff = tanh_q16(drive) - tanh_q16(ladder_state[k]);
			step = round_shift(diff * longint'(tuning_now), 2 * TH_FRAC - STAGE_FRAC);
			ladder_state[k] = clamp(ladder_state[k] + step, STAGE_LO, STAGE_HI);
			drive = ladder_state[k];
		end
		return SAMPLE_W'(clamp(round_shift(ladder_state[NUM_STAGES-1],
			STAGE_FRAC - SAMPLE_FRAC), -32768, 32767));
	endfunction

	// sender: offer the next queued word, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid     <= 1'b0;
			sample_if.sample_in <= '0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				filtered_due.push_back(ladder_advance(sample_if.sample_in));
				words_sent++;
			end
			// a word still waiting for ready stays on the bus
			if (!sample_if.valid || sample_if.ready) begin
				if (samples_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					sample_if.valid     <= 1'b1;
					sample_if.sample_in <= samples_to_send.pop_front();
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each filtered word, stall at random or on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				words_checked++;
				if (filtered_due.size() == 0) begin
					$error("sample_out: no word expected, got %0d", result_if.sample_out);
					failures++;
				end else begin
					filtered_want = filtered_due.pop_front();
					if (result_if.sample_out !== filtered_want) begin
						$error("sample_out: expected %0d, got %0d",
							filtered_want, result_if.sample_out);
						failures++;
					end
				end
			end
			// long hold-off so the block backs up into the sample channel
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready)
				|| (result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d words owed",
				quiet_cycles, filtered_due.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// coefficient write, only while the block holds nothing
	task automatic write_coeff(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (index == nll_pkg::REG_TUNING)
			tuning_now = value;
		else
			feedback_now = value;
	endtask

	task automatic set_coeffs(input logic [CFG_W-1:0] tuning,
			input logic [CFG_W-1:0] feedback);
		write_coeff(nll_pkg::REG_TUNING, tuning);
		write_coeff(nll_pkg::REG_FEEDBACK, feedback);
		settings_used++;
	endtask

	// every queued word sent and every filtered word back
	task automatic drain();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || filtered_due.size() != 0
			|| sample_if.valid);
	endtask

	// runs of noise, held steps, low-level signal and full-scale square
	task automatic queue_samples(input int count);
		shape_t                     shape;
		int                         run_len;
		int                         queued;
		logic signed [SAMPLE_W-1:0] level;
		queued = 0;
		while (queued < count) begin
			shape   = shape_t'($urandom_range(3));
			run_len = $urandom_range(40, 4);
			level   = SAMPLE_W'($urandom);
			for (int n = 0; n < run_len && queued < count; n++) begin
				case (shape)
				SHAPE_NOISE:  samples_to_send.push_back(SAMPLE_W'($urandom));
				SHAPE_STEP:   samples_to_send.push_back(level);
				SHAPE_QUIET:  samples_to_send.push_back(
					SAMPLE_W'(int'($urandom_range(2047)) - 1024));
				default:      samples_to_send.push_back(n[2] ? 16'sh7FFF : 16'sh8000);
				endcase
				queued++;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = nll_pkg::REG_TUNING;
		cfg_data          = '0;
		tuning_now        = nll_pkg::TUNING_RESET;
		feedback_now      = nll_pkg::FEEDBACK_RESET;
		sender_idle_pct   = 9;
		receiver_idle_pct = 66;
		hold_requests     = 0;
		holds_served      = 0;
		hold_left         = 0;
		quiet_cycles      = 0;
		words_sent        = 0;
		words_checked     = 0;
		failures          = 0;
		settings_used     = 1;
		for (int k = 0; k < NUM_STAGES; k++)
			ladder_state[k] = 0;
		build_tanh_points();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: zero, both rails held, lone lsb and bit patterns
		@(negedge clk);
		samples_to_send = '{16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh8000, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA, 16'sd0};
		drain();

		// both registers past their range: stages hit their rails and the
		// feedback sum leaves the tanh table on both sides
		set_coeffs(CFG_FULL, CFG_FULL);
		@(negedge clk);
		samples_to_send = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, -16'sd1, 16'sd0, 16'sd0};
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// idle pattern: sender light then heavy, then none
			@(negedge clk);
			if (ph < 3) begin
				sender_idle_pct   = 9;
				receiver_idle_pct = 66;
			end else if (ph < 6) begin
				sender_idle_pct   = 66;
				receiver_idle_pct = 9;
			end else begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			case (ph)
			0: set_coeffs(nll_pkg::TUNING_RESET, nll_pkg::FEEDBACK_RESET);
			1: set_coeffs(TUNING_TOP, FEEDBACK_TOP);
			2: set_coeffs(CFG_W'($urandom_range(425984)), CFG_W'($urandom_range(262144)));
			3: set_coeffs('0, CFG_W'($urandom_range(262144)));
			4: set_coeffs(CFG_FULL, CFG_FULL);
			5: set_coeffs(CFG_W'($urandom), CFG_W'($urandom));
			6: set_coeffs(CFG_W'($urandom_range(425984)), '0);
			default: set_coeffs(TUNING_TOP, CFG_W'($urandom_range(262144)));
			endcase
			@(negedge clk);
			queue_samples(PHASE_WORDS);
			if (ph == 6) begin
				repeat (20) @(negedge clk);
				hold_requests++;
			end
			drain();
		end

		repeat (SETTLE_TAIL) @(posedge clk);
		$display("sent %0d sample words, checked %0d filtered words", words_sent,
			words_checked);
		$display("over %0d coefficient settings, %0d mismatches", settings_used,
			failures);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
